### rtl/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// shared types, constants and controller codes of the skyline atlas packer
// ----------------------------------------------------------------------------
`default_nettype none
package sap_pkg;

  localparam int ATLAS_SIZE_DEF = 1024;
  localparam int MAX_PAGES_DEF  = 4;
  localparam int DIM_W          = 11;
  localparam int GEN_W          = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_CLEAR,
    ST_CLEAR_WAIT,
    ST_WRITE,
    ST_WRITE_WAIT,
    ST_OUT
  } sap_state_t;

  // datapath sweep modes
  typedef enum logic [1:0] {
    M_IDLE,
    M_SCAN,
    M_CLEAR,
    M_WRITE
  } sap_mode_t;

  // controller to datapath
  typedef struct packed {
    logic scan_start;
    logic clear_start;
    logic write_start;
  } sap_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic found;
  } sap_stat_t;

endpackage
`default_nettype wire

### rtl/skyline_atlas_packer.sv
// ----------------------------------------------------------------------------
// skyline_atlas_packer
// bottom-left skyline rectangle packer over several square atlas pages
// ----------------------------------------------------------------------------
// a tick is taken and gives no result; a place request scans each tried page
// through one ram port, up to MAX_PAGES+1 scans, with a clear sweep of each
// page that is opened or evicted and a write sweep to raise the placed columns
// throughput: one item at a time, next item accepted the cycle after the result is taken
// reset: rst synchronous, clears counters, page stamps and open count
// ----------------------------------------------------------------------------
`default_nettype none
module skyline_atlas_packer
  import sap_pkg::*;
#(
  parameter int ATLAS_SIZE = ATLAS_SIZE_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // action, rect_width, rect_height
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // placed, page_index, pos_x, pos_y,
                                     // evicted, evicted_page, generation
);

  localparam int COL_W = $clog2(ATLAS_SIZE);
  localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  sap_cmd_t         cmd;
  sap_stat_t        stat;
  logic [PG_W-1:0]  page;
  logic [DIM_W-1:0] w, h;
  logic [COL_W-1:0] best_x;
  logic [DIM_W-1:0] best_top;
  logic             ready, placed, evicted;
  logic [GEN_W-1:0] generation;
  logic             acc;

  assign acc      = s_tvalid && s_tready;
  assign s_tready = ready;

  always_ff @(posedge clk) begin
    if (acc && !s_tdata[0]) begin
      w <= s_tdata[11:1];
      h <= s_tdata[22:12];
    end
  end

  sap_ctrl #(.MAX_PAGES(MAX_PAGES)) u_ctrl (
    .clk, .rst,
    .start       (acc && !s_tdata[0]),
    .tick        (acc && s_tdata[0]),
    .stat,
    .out_taken   (m_tvalid && m_tready),
    .ready,
    .cmd,
    .page,
    .res_valid   (m_tvalid),
    .res_placed  (placed),
    .res_evicted (evicted),
    .generation
  );

  sap_datapath #(.ATLAS_SIZE(ATLAS_SIZE), .MAX_PAGES(MAX_PAGES)) u_dp (
    .clk, .rst, .cmd, .page, .w, .h, .stat, .best_x, .best_top
  );

  always_comb begin
    m_tdata        = '0;
    m_tdata[0]     = placed;
    m_tdata[2:1]   = placed ? 2'(page) : 2'b0;
    m_tdata[12:3]  = placed ? 10'(best_x) : 10'b0;
    m_tdata[22:13] = placed ? 10'(best_top) : 10'b0;
    m_tdata[23]    = evicted;
    m_tdata[25:24] = evicted ? 2'(page) : 2'b0;
    m_tdata[57:26] = generation;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    (generation != $past(generation)) |-> evicted)
    else $error("generation moved without eviction");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while waiting");

endmodule
`default_nettype wire

### rtl/sap_ram.sv
// ----------------------------------------------------------------------------
// sap_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module sap_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### rtl/sap_datapath.sv
// ----------------------------------------------------------------------------
// sap_datapath
// skyline memory, column scan with window maximum, raise and clear sweeps
// ----------------------------------------------------------------------------
`default_nettype none
module sap_datapath
  import sap_pkg::*;
#(
  parameter int ATLAS_SIZE = ATLAS_SIZE_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  localparam int COL_W = $clog2(ATLAS_SIZE),
  localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sap_cmd_t         cmd,
  input  wire logic [PG_W-1:0]  page,
  input  wire logic [DIM_W-1:0] w,
  input  wire logic [DIM_W-1:0] h,
  output sap_stat_t             stat,
  output logic [COL_W-1:0]      best_x,
  output logic [DIM_W-1:0]      best_top
);

  localparam logic [COL_W:0] LAST = (COL_W + 1)'(ATLAS_SIZE - 1);
  localparam logic [DIM_W:0] AS   = (DIM_W + 1)'(ATLAS_SIZE);

  sap_mode_t        mode, mode_next;
  logic [COL_W:0]   col, col_next;   // column issued to the ram
  logic [COL_W:0]   j;               // column whose data is on rdata
  logic             rvalid, rvalid_next;
  logic [DIM_W-1:0] run_max;         // max over columns since the window start
  logic [COL_W:0]   run_start, run_start_next;
  logic             found, found_next;
  logic [COL_W-1:0] best_x_next;
  logic [DIM_W-1:0] best_top_next;
  logic [DIM_W-1:0] rdata;
  logic             we;
  logic [DIM_W-1:0] wdata;
  logic [COL_W:0]   wend;
  logic [DIM_W-1:0] cur_max;
  logic [COL_W:0]   span;
  logic             oversize;
  logic             win_done;
  logic             better;

  // candidate at x covers x..x+w-1; after each candidate the window
  // restarts one column further on
  assign cur_max  = (j == run_start || rdata > run_max) ? rdata : run_max;
  assign span     = j - run_start + 1'b1;
  assign wend     = {1'b0, best_x} + w[COL_W:0];
  assign oversize = (w > DIM_W'(ATLAS_SIZE)) || (h > DIM_W'(ATLAS_SIZE));
  assign win_done = rvalid && (span == w[COL_W:0]);
  assign better   = (({1'b0, cur_max} + {1'b0, h}) <= AS) &&
                    (!found || cur_max < best_top);

  sap_ram #(.WIDTH(DIM_W), .DEPTH(MAX_PAGES * ATLAS_SIZE)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  ({page, col[COL_W-1:0]}),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    mode_next      = mode;
    col_next       = col;
    rvalid_next    = 1'b0;
    run_start_next = run_start;
    found_next     = found;
    best_x_next    = best_x;
    best_top_next  = best_top;
    case (mode)
      M_IDLE: begin
        if (cmd.scan_start) begin
          mode_next      = M_SCAN;
          col_next       = '0;
          run_start_next = '0;
          found_next     = (w == '0) && !oversize;
          best_x_next    = '0;
          best_top_next  = '0;
        end else if (cmd.clear_start) begin
          mode_next = M_CLEAR;
          col_next  = '0;
        end else if (cmd.write_start) begin
          mode_next = M_WRITE;
          col_next  = {1'b0, best_x};
        end
      end
      M_SCAN: begin
        if (w == '0 || oversize) begin
          mode_next = M_IDLE;
        end else if (win_done) begin
          if (better) begin
            found_next    = 1'b1;
            best_top_next = cur_max;
            best_x_next   = run_start[COL_W-1:0];
          end
          if (j == LAST) begin
            mode_next = M_IDLE;
          end else begin
            run_start_next = run_start + 1'b1;
            col_next       = run_start + 1'b1;
          end
        end else begin
          rvalid_next = 1'b1;
          col_next    = col + 1'b1;
        end
      end
      M_CLEAR: begin
        col_next = col + 1'b1;
        if (col == LAST) mode_next = M_IDLE;
      end
      M_WRITE: begin
        col_next = col + 1'b1;
        if (col + 1'b1 >= wend || w == '0) mode_next = M_IDLE;
      end
      default: mode_next = M_IDLE;
    endcase
  end

  always_comb begin
    we    = (mode == M_CLEAR) || ((mode == M_WRITE) && (w != '0));
    wdata = (mode == M_WRITE) ? DIM_W'(best_top + h) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      col       <= '0;
      j         <= '0;
      rvalid    <= 1'b0;
      run_max   <= '0;
      run_start <= '0;
      found     <= 1'b0;
      best_x    <= '0;
      best_top  <= '0;
    end else begin
      mode      <= mode_next;
      col       <= col_next;
      j         <= col;
      rvalid    <= rvalid_next;
      run_start <= run_start_next;
      found     <= found_next;
      best_x    <= best_x_next;
      best_top  <= best_top_next;
      if (rvalid) run_max <= cur_max;
    end
  end

  assign stat.busy  = (mode != M_IDLE);
  assign stat.found = found;

endmodule
`default_nettype wire

### rtl/sap_ctrl.sv
// ----------------------------------------------------------------------------
// sap_ctrl
// request sequencer: page order, page opening, lru eviction, result capture
// ----------------------------------------------------------------------------
`default_nettype none
module sap_ctrl
  import sap_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  localparam int PG_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
  localparam int NP_W = $clog2(MAX_PAGES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            tick,
  input  wire sap_stat_t       stat,
  input  wire logic            out_taken,
  output logic                 ready,
  output sap_cmd_t             cmd,
  output logic [PG_W-1:0]      page,
  output logic                 res_valid,
  output logic                 res_placed,
  output logic                 res_evicted,
  output logic [GEN_W-1:0]     generation
);

  sap_state_t       state, state_next;
  logic [NP_W-1:0]  pages_open;
  logic [GEN_W-1:0] frame_count;
  logic [GEN_W-1:0] last_used [MAX_PAGES];
  logic             retry;     // page was just cleared, this is the last try
  logic [PG_W-1:0]  lru;
  logic             more_pages;
  logic             scan_miss;

  assign more_pages = (NP_W'(page) + 1'b1) < pages_open;
  assign scan_miss  = !stat.busy && !stat.found;

  always_comb begin
    lru = '0;
    for (int p = 1; p < MAX_PAGES; p++) begin
      if (last_used[p] < last_used[lru]) lru = PG_W'(p);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        state_next = (pages_open == '0) ? ST_CLEAR : ST_SCAN;
      end
      ST_SCAN:      state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: if (!stat.busy) begin
        if (stat.found)      state_next = ST_WRITE;
        else if (retry)      state_next = ST_OUT;
        else if (more_pages) state_next = ST_SCAN;
        else                 state_next = ST_CLEAR;
      end
      ST_CLEAR:      state_next = ST_CLEAR_WAIT;
      ST_CLEAR_WAIT: if (!stat.busy) state_next = ST_SCAN;
      ST_WRITE:      state_next = ST_WRITE_WAIT;
      ST_WRITE_WAIT: if (!stat.busy) state_next = ST_OUT;
      ST_OUT:        if (out_taken) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.scan_start  = (state == ST_SCAN);
    cmd.clear_start = (state == ST_CLEAR);
    cmd.write_start = (state == ST_WRITE);
    ready           = (state == ST_IDLE);
    res_valid       = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pages_open  <= '0;
      frame_count <= '0;
      generation  <= '0;
      retry       <= 1'b0;
      page        <= '0;
      res_placed  <= 1'b0;
      res_evicted <= 1'b0;
      for (int p = 0; p < MAX_PAGES; p++) last_used[p] <= '0;
    end else begin
      state <= state_next;
      if (tick) frame_count <= frame_count + 1'b1;
      case (state)
        ST_IDLE: if (start) begin
          page        <= '0;
          retry       <= (pages_open == '0);
          res_evicted <= 1'b0;
          res_placed  <= 1'b0;
          if (pages_open == '0) pages_open <= pages_open + 1'b1;
        end
        ST_SCAN_WAIT: if (scan_miss && !retry) begin
          if (more_pages) begin
            page <= page + 1'b1;
          end else if (pages_open < NP_W'(MAX_PAGES)) begin
            page       <= PG_W'(pages_open);
            pages_open <= pages_open + 1'b1;
            retry      <= 1'b1;
          end else begin
            page        <= lru;
            generation  <= generation + 1'b1;
            res_evicted <= 1'b1;
            retry       <= 1'b1;
          end
        end
        ST_CLEAR: last_used[page] <= frame_count;
        ST_WRITE: begin
          last_used[page] <= frame_count;
          res_placed      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
